// ===== hdl/rect_polygon_clipper_core_defines.svh =====
// Assertion macros shared by the clipper RTL.
`ifndef RECT_POLYGON_CLIPPER_CORE_DEFINES_SVH
`define RECT_POLYGON_CLIPPER_CORE_DEFINES_SVH
// Overlapping implication: antecedent implies consequent in the same cycle.
`define RPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/rpc_pkg.sv =====
// Shared types and constants for the rectangle polygon clipper.
`timescale 1ns / 1ps
package rpc_pkg;
  localparam int NUM_STAGES = 4;
  localparam logic [1:0] STG_BOTTOM = 2'd0;
  localparam logic [1:0] STG_RIGHT  = 2'd1;
  localparam logic [1:0] STG_TOP    = 2'd2;
  localparam logic [1:0] STG_LEFT   = 2'd3;
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;
  typedef struct packed {
    logic busy;
    logic idle;
  } rpc_status_t;
endpackage

// ===== hdl/rpc_fifo.sv =====
// Short vertex queue between the input front end and the clipping engine.
`timescale 1ns / 1ps
module rpc_fifo #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr_fire, rd_fire;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_fire) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end
  end
endmodule

// ===== hdl/rpc_muldiv.sv =====
// Sequential signed a*b/c unit: registered multiply, then restoring division.
`timescale 1ns / 1ps
`include "rect_polygon_clipper_core_defines.svh"
module rpc_muldiv #(
  parameter int W = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  output logic                done,
  output logic signed [2*W-1:0] q
);
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;
  st_t st_r;
  logic [W-1:0] ma_r, mb_r, mc_r;
  logic neg_r;
  logic [PW-1:0] prod_r, quo_r;
  logic [W:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic [W:0] rsh;
  logic [W:0] rsub;

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    mag_f = v[W-1] ? W'(-v) : W'(v);
  endfunction

  assign rsh  = {rem_r[W-1:0], prod_r[PW-1]};
  assign rsub = rsh - {1'b0, mc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          ma_r <= mag_f(a);
          mb_r <= mag_f(b);
          mc_r <= mag_f(c);
          neg_r <= (a[W-1] ^ b[W-1]) ^ c[W-1];
          st_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= PW'(ma_r) * PW'(mb_r);
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= CW'(PW);
          st_r <= S_DIV;
        end
        S_DIV: begin
          prod_r <= {prod_r[PW-2:0], 1'b0};
          if (!rsub[W]) begin
            rem_r <= rsub;
            quo_r <= {quo_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            quo_r <= {quo_r[PW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) st_r <= S_FIN;
        end
        S_FIN: begin
          q <= (mc_r == '0) ? '0 : (neg_r ? -$signed(quo_r) : $signed(quo_r));
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `RPC_ASSERT_NEXT(a_done_from_fin, clk, rst_n, st_r == S_FIN, done)
  `RPC_ASSERT_IMPL(a_cnt_live, clk, rst_n, st_r == S_DIV, cnt_r != '0)
  `RPC_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, st_r == S_IDLE && start, st_r == S_MUL)
endmodule

// ===== hdl/rpc_engine.sv =====
// Back end: runs the four boundary stages on a worklist and drives the output.
`timescale 1ns / 1ps
`include "rect_polygon_clipper_core_defines.svh"
module rpc_engine #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [CW-1:0] left_edge,
  input  logic signed [CW-1:0] bottom_edge,
  input  logic signed [CW-1:0] right_edge,
  input  logic signed [CW-1:0] top_edge,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [2*CW:0]        q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CW-1:0]        out_x,
  output logic [CW-1:0]        out_y,
  output logic                 out_fin,
  output logic                 out_empty,
  output rpc_pkg::rpc_status_t status
);
  import rpc_pkg::*;
  localparam int DW = CW + 1;
  // Worklist entries: a pending point with its stage level (sl_r).
  localparam int WL = 8;
  localparam int WA = $clog2(WL);
  typedef enum logic [2:0] {
    E_IDLE, E_PICK, E_DIV, E_EMIT, E_HOLD, E_LAST, E_OUT
  } est_t;
  est_t st_r;

  logic signed [CW-1:0] fx_r [NUM_STAGES];
  logic signed [CW-1:0] fy_r [NUM_STAGES];
  logic signed [CW-1:0] px_r [NUM_STAGES];
  logic signed [CW-1:0] py_r [NUM_STAGES];
  logic [NUM_STAGES-1:0] started_r;
  logic any_r;
  logic signed [CW-1:0] hx_r, hy_r;
  logic closing_r;

  // Stack of pending points (depth-first keeps model order).
  logic signed [CW-1:0] sx_r [WL];
  logic signed [CW-1:0] sy_r [WL];
  logic [2:0] sl_r [WL];
  logic [WA:0] sp_r;
  logic [2:0] close_k_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic [2:0] cl_r;
  logic is_close_r;
  logic push_pt_r;

  logic md_start, md_done;
  logic signed [DW-1:0] md_a, md_b, md_c;
  logic signed [2*DW-1:0] md_q;
  logic signed [CW-1:0] base_r;
  logic odd_r;

  rpc_muldiv #(.W(DW)) u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(md_a), .b(md_b), .c(md_c), .done(md_done), .q(md_q)
  );

  function automatic logic inside_f(input logic [1:0] k, input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] l,
                                    input logic signed [CW-1:0] bo,
                                    input logic signed [CW-1:0] r,
                                    input logic signed [CW-1:0] t);
    unique case (k)
      STG_BOTTOM: inside_f = y >= bo;
      STG_RIGHT:  inside_f = x <= r;
      STG_TOP:    inside_f = y <= t;
      default:    inside_f = x >= l;
    endcase
  endfunction

  // Current edge: p = start (prev), s = end (new point or first vertex).
  logic [1:0] k2;
  logic signed [CW-1:0] ex, ey, sxp, syp;
  logic s_in, p_in, crosses, has_edge;
  logic signed [CW-1:0] bnd;
  always_comb begin
    k2 = cl_r[1:0];
    if (is_close_r) begin
      ex = fx_r[k2];
      ey = fy_r[k2];
    end else begin
      ex = cx_r;
      ey = cy_r;
    end
    sxp = px_r[k2];
    syp = py_r[k2];
    s_in = inside_f(k2, ex, ey, left_edge, bottom_edge, right_edge, top_edge);
    p_in = inside_f(k2, sxp, syp, left_edge, bottom_edge, right_edge, top_edge);
    has_edge = started_r[k2];
    crosses = has_edge && (s_in != p_in);
    unique case (k2)
      STG_BOTTOM: bnd = bottom_edge;
      STG_RIGHT:  bnd = right_edge;
      STG_TOP:    bnd = top_edge;
      default:    bnd = left_edge;
    endcase
    if (k2[0]) begin
      md_a = DW'(bnd) - DW'(ex);
      md_b = DW'(syp) - DW'(ey);
      md_c = DW'(sxp) - DW'(ex);
    end else begin
      md_a = DW'(bnd) - DW'(ey);
      md_b = DW'(sxp) - DW'(ex);
      md_c = DW'(syp) - DW'(ey);
    end
  end
  assign md_start = (st_r == E_PICK) && (cl_r != 3'd4) && crosses;

  assign q_ready = (st_r == E_IDLE);
  assign status.busy = (st_r != E_IDLE);
  assign status.idle = (st_r == E_IDLE) && !out_valid;

  logic [WA-1:0] top_i;
  assign top_i = WA'(sp_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
      started_r <= '0;
      any_r <= 1'b0;
      sp_r <= '0;
      out_valid <= 1'b0;
      close_k_r <= '0;
      closing_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        E_IDLE: if (q_valid) begin
          cx_r <= $signed(q_data[CW-1:0]);
          cy_r <= $signed(q_data[2*CW-1:CW]);
          closing_r <= q_data[2*CW];
          cl_r <= 3'd0;
          is_close_r <= 1'b0;
          close_k_r <= 3'd0;
          st_r <= E_PICK;
        end
        E_PICK: begin
          if (cl_r == 3'd4) begin
            st_r <= E_HOLD;
          end else begin
            if (!is_close_r) begin
              px_r[k2] <= cx_r;
              py_r[k2] <= cy_r;
              if (!started_r[k2]) begin
                fx_r[k2] <= cx_r;
                fy_r[k2] <= cy_r;
                started_r[k2] <= 1'b1;
              end
            end else begin
              started_r[k2] <= 1'b0;
            end
            push_pt_r <= !is_close_r && s_in;
            odd_r <= k2[0];
            base_r <= k2[0] ? ey : ex;
            st_r <= crosses ? E_DIV : E_EMIT;
          end
        end
        E_DIV: if (md_done) begin
          // Intersection goes to next level first, then the point itself.
          if (push_pt_r) begin
            sx_r[WA'(sp_r)] <= cx_r;
            sy_r[WA'(sp_r)] <= cy_r;
            sl_r[WA'(sp_r)] <= cl_r + 3'd1;
            sp_r <= sp_r + 1'b1;
          end
          push_pt_r <= 1'b0;
          if (odd_r) begin
            cx_r <= bnd;
            cy_r <= CW'(base_r + CW'(md_q));
          end else begin
            cx_r <= CW'(base_r + CW'(md_q));
            cy_r <= bnd;
          end
          cl_r <= cl_r + 3'd1;
          is_close_r <= 1'b0;
          st_r <= E_PICK;
        end
        E_EMIT: begin
          if (push_pt_r) begin
            cl_r <= cl_r + 3'd1;
            is_close_r <= 1'b0;
            st_r <= E_PICK;
          end else begin
            st_r <= E_LAST;
          end
        end
        E_HOLD: if (!out_valid || out_ready) begin
          if (any_r) begin
            out_valid <= 1'b1;
            out_x <= hx_r;
            out_y <= hy_r;
            out_fin <= 1'b0;
            out_empty <= 1'b0;
          end
          hx_r <= cx_r;
          hy_r <= cy_r;
          any_r <= 1'b1;
          st_r <= E_LAST;
        end
        E_LAST: begin
          if (sp_r != '0) begin
            cx_r <= sx_r[top_i];
            cy_r <= sy_r[top_i];
            cl_r <= sl_r[top_i];
            is_close_r <= 1'b0;
            sp_r <= sp_r - 1'b1;
            st_r <= E_PICK;
          end else if (closing_r && close_k_r != 3'd4) begin
            cl_r <= close_k_r;
            is_close_r <= 1'b1;
            close_k_r <= close_k_r + 3'd1;
            st_r <= E_PICK;
          end else if (closing_r) begin
            st_r <= E_OUT;
          end else begin
            st_r <= E_IDLE;
          end
        end
        E_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_x <= any_r ? hx_r : '0;
          out_y <= any_r ? hy_r : '0;
          out_fin <= 1'b1;
          out_empty <= !any_r;
          any_r <= 1'b0;
          hx_r <= '0;
          hy_r <= '0;
          closing_r <= 1'b0;
          st_r <= E_IDLE;
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  `RPC_ASSERT_IMPL(a_stack_bound, clk, rst_n, 1'b1, sp_r <= (WA+1)'(WL))
  `RPC_ASSERT_IMPL(a_empty_is_final, clk, rst_n, out_valid && out_empty, out_fin)
  `RPC_ASSERT_NEXT(a_out_clears_any, clk, rst_n,
    st_r == E_OUT && (!out_valid || out_ready), !any_r && out_valid)
endmodule

// ===== hdl/rect_polygon_clipper_core.sv =====
// Top level of the rectangle polygon clipper.
// Usage:
//  - in_ channel: one polygon vertex per beat; in_tuser marks the closing vertex.
//  - out_ channel: clipped vertices; out_tlast on the last one of a polygon,
//    out_tuser set on a single beat when the whole polygon is clipped away.
//  - cfg_: write the rectangle (0 left, 1 bottom, 2 right, 3 top) while idle.
// Processing: a vertex sits in a 4-entry queue, then the engine walks it
// through four boundary stages; the engine takes the next vertex only
// once it is idle again. Each intersection uses the shared multiply/divide
// unit, and the closing vertex adds four close steps.
// Output is delayed by one vertex so the final beat carries tlast.
// Reset clears stage state, queue and output; the rectangle resets to
// xmin=ymin=0 and xmax=ymax=largest positive value.
// When out_tready is low the engine holds its result and stops; the queue
// keeps taking vertices until it fills.
`timescale 1ns / 1ps
module rect_polygon_clipper_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // in_tdata: in_x, in_y (zero padded to bytes)
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // in_tuser: closes_polygon
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_tdata: out_x, out_y (zero padded to bytes)
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,
  // out_tuser: clipped_away
  output logic out_tuser,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_wdata
);
  import rpc_pkg::*;
  localparam int CW = COORD_WIDTH;
  localparam int TW = ((2*CW+7)/8)*8;
  logic signed [CW-1:0] left_r, bottom_r, right_r, top_r;
  logic q_valid, q_ready;
  logic [2*CW:0] q_data;
  logic [CW-1:0] ox, oy;
  rpc_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      bottom_r <= '0;
      right_r <= {1'b0, {(CW-1){1'b1}}};
      top_r <= {1'b0, {(CW-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   left_r <= cfg_wdata;
        REG_BOTTOM: bottom_r <= cfg_wdata;
        REG_RIGHT:  right_r <= cfg_wdata;
        REG_TOP:    top_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rpc_fifo #(.WIDTH(2*CW+1), .DEPTH(4)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready),
    .wr_data({in_tuser, in_tdata[2*CW-1:0]}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  rpc_engine #(.CW(CW)) u_eng (
    .clk(clk), .rst_n(rst_n),
    .left_edge(left_r), .bottom_edge(bottom_r),
    .right_edge(right_r), .top_edge(top_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_x(ox), .out_y(oy), .out_fin(out_tlast), .out_empty(out_tuser),
    .status(status)
  );

  assign out_tdata = TW'({oy, ox});
endmodule
